### rtl/rmf_pkg.sv
package rmf_pkg;

	// channel layout
	localparam int CHANNELS = 4;
	localparam int CH_W = 2;

	// field widths
	localparam int SAMPLE_W = 32;
	localparam int WIN_W = 16;
	localparam int TDATA_W = 40;
	localparam int PAD_W = TDATA_W - CH_W - SAMPLE_W;

	// divider: magnitude of a 33-bit difference, one quotient bit per cycle
	localparam int DIV_W = SAMPLE_W + 1;
	localparam int STEP_W = $clog2(DIV_W + 1);

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} rmf_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/rmf_div.sv
// restoring bit-serial divider, unsigned magnitude by unsigned divisor
module rmf_div
	import rmf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIV_W-1:0]      dividend,
	input  logic [WIN_W-1:0]      divisor,
	output logic [DIV_W-1:0]      quotient,
	output div_stat_t             stat
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [WIN_W-1:0]  rem_q;
	logic [WIN_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  quo_q;

	logic [WIN_W:0] trial;
	logic           fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder stays below the divisor, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= WIN_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[WIN_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (step_q == STEP_W'(DIV_W - 1));

endmodule

### rtl/recursive_mean_filter.sv
// recursive mean filter: keeps a running mean per channel and a shared vector
// count n that saturates at window_length (0 is taken as 1). each input word is
// one signed Q15.16 sample for one channel, tlast marks the end of a vector and
// advances n. the new mean is prev + (sample - prev) / min(n, window), the
// quotient truncated toward zero; while n is 0 the mean is held, so the first
// vector only primes the counter. every input word gives exactly one output
// word carrying the channel, the updated mean and tlast. an item is accepted, then
// the bit-serial divider finds one quotient bit per cycle over the 33-bit
// difference, then the mean is formed and handed to the output register; during
// warm-up the divider is skipped, and the next word waits until the item is
// through. the output register lets a finished word wait while the next input
// is accepted. write window_length only while the block is idle.
module recursive_mean_filter
	import rmf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               window_length_we,
	input  logic [WIN_W-1:0]   window_length,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // channel[1:0], sample[33:2], zero pad
	input  logic               s_tlast,   // end_of_vector
	// output stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // out_channel[1:0], mean_value[33:2], zero pad
	output logic               m_tlast    // out_last
);

	rmf_state_t state_q;

	logic [SAMPLE_W-1:0] mean_q [CHANNELS];
	logic [WIN_W-1:0]    count_q;
	logic [WIN_W-1:0]    win_q;

	// item context held while the divider runs
	logic [CH_W-1:0]     ch_q;
	logic                last_q;
	logic                neg_q;
	logic                skip_q;
	logic                chok_q;

	logic                m_valid_q;
	logic [CH_W-1:0]     m_ch_q;
	logic [SAMPLE_W-1:0] m_mean_q;
	logic                m_last_q;

	// input unpacking
	logic [CH_W-1:0]     in_ch;
	logic [SAMPLE_W-1:0] in_sample;
	logic                in_ok;
	logic                accept;

	// divisor and difference
	logic [WIN_W-1:0]    win_eff;
	logic [WIN_W-1:0]    divisor;
	logic [SAMPLE_W-1:0] prev_in;
	logic [DIV_W-1:0]    diff;
	logic [DIV_W-1:0]    mag;

	// final update
	logic [DIV_W-1:0]    quo;
	logic [SAMPLE_W-1:0] prev_cur;
	logic [SAMPLE_W-1:0] step;
	logic [SAMPLE_W-1:0] new_mean;
	logic                out_free;

	div_stat_t           div_stat;

	assign in_ch     = s_tdata[CH_W-1:0];
	assign in_sample = s_tdata[CH_W+SAMPLE_W-1:CH_W];
	assign in_ok     = int'(in_ch) < CHANNELS;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign win_eff = (win_q == '0) ? WIN_W'(1) : win_q;
	assign divisor = (count_q < win_eff) ? count_q : win_eff;

	// 33-bit difference and its magnitude; -2^32 maps to 2^32 unsigned
	assign prev_in = mean_q[in_ch];
	assign diff    = {in_sample[SAMPLE_W-1], in_sample} - {prev_in[SAMPLE_W-1], prev_in};
	assign mag     = diff[DIV_W-1] ? (~diff + DIV_W'(1)) : diff;

	rmf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && in_ok && (count_q != '0)),
		.dividend (mag),
		.divisor  (divisor),
		.quotient (quo),
		.stat     (div_stat)
	);

	// truncated quotient back to a signed step; the new mean stays between
	// prev and sample, so 32 bits are enough
	assign prev_cur = mean_q[ch_q];
	assign step     = skip_q ? '0 :
	                  (neg_q ? (~quo[SAMPLE_W-1:0] + SAMPLE_W'(1)) : quo[SAMPLE_W-1:0]);
	assign new_mean = prev_cur + step;
	assign out_free = !m_valid_q || m_tready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			win_q     <= WIN_RESET;
			m_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				mean_q[i] <= '0;
			end
		end else begin
			if (window_length_we) begin
				win_q <= window_length;
			end
			// a new word loads as the old one leaves
			if ((state_q == ST_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// counter moves at accept, the divisor is already taken
						if (s_tlast && (count_q < win_eff)) begin
							count_q <= count_q + WIN_W'(1);
						end
						if (in_ok && (count_q != '0)) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (chok_q) begin
							mean_q[ch_q] <= new_mean;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item context and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= in_ch;
			last_q <= s_tlast;
			neg_q  <= diff[DIV_W-1];
			skip_q <= !in_ok || (count_q == '0);
			chok_q <= in_ok;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_ch_q   <= ch_q;
			m_mean_q <= chok_q ? new_mean : '0;
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_mean_q, m_ch_q};
	assign m_tlast  = m_last_q;

	// divider only finishes while the sequencer waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// no new word is taken while the divider still runs
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy)
		else $error("input accepted while divider busy");

	// vector count only ever steps up by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + WIN_W'(1)))
		else $error("vector count moved by more than one");

	// a result is loaded only on the way out of the done state
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_DONE))
		else $error("output loaded outside the done state");

endmodule
